// ===== hw/rtl/bbsrt_pkg.sv =====
// Shared constants and control types for the box bound step ratio test.
// No dependencies; every other file of the block imports this package.
package bbsrt_pkg;

   localparam int BBSRT_DATA_WIDTH    = 32;
   localparam int BBSRT_FRACTION_BITS = 16;

   // Request from the sequencer to the divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Status back from the divider: done pulses once per division, overflow holds until the next.
   typedef struct packed {
      logic done;
      logic overflow;
   } div_stat_type;

endpackage

// ===== hw/rtl/bbsrt_req_if.sv =====
// Input channel of the box bound step ratio test: one vector element per word.
// Depends on bbsrt_pkg for the default data width.
interface bbsrt_req_if import bbsrt_pkg::*; #(
   parameter int DATA_WIDTH = BBSRT_DATA_WIDTH
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] position;
   logic signed [DATA_WIDTH-1:0] upper_bound;
   logic                         upper_finite;
   logic signed [DATA_WIDTH-1:0] lower_bound;
   logic                         lower_finite;
   logic signed [DATA_WIDTH-1:0] step_direction;
   logic                         final_element;

   modport source (
      output valid, position, upper_bound, upper_finite, lower_bound, lower_finite,
             step_direction, final_element,
      input  ready
   );
   modport sink (
      input  valid, position, upper_bound, upper_finite, lower_bound, lower_finite,
             step_direction, final_element,
      output ready
   );
endinterface

// ===== hw/rtl/bbsrt_rsp_if.sv =====
// Result channel of the box bound step ratio test: breakpoint and running minimum.
// Depends on bbsrt_pkg for the default data width.
interface bbsrt_rsp_if import bbsrt_pkg::*; #(
   parameter int DATA_WIDTH = BBSRT_DATA_WIDTH
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] breakpoint;
   logic                         breakpoint_infinite;
   logic signed [DATA_WIDTH-1:0] min_step;
   logic                         min_infinite;
   logic                         vector_done;

   modport source (
      output valid, breakpoint, breakpoint_infinite, min_step, min_infinite, vector_done,
      input  ready
   );
   modport sink (
      input  valid, breakpoint, breakpoint_infinite, min_step, min_infinite, vector_done,
      output ready
   );
endinterface

// ===== hw/rtl/bbsrt_divider.sv =====
// Radix-2 restoring divider: (dividend << FRACTION_BITS) / divisor, unsigned.
// An overflow check state, then one quotient bit a cycle. Depends on bbsrt_pkg.
module bbsrt_divider import bbsrt_pkg::*; #(
   parameter int DATA_WIDTH    = BBSRT_DATA_WIDTH,
   parameter int FRACTION_BITS = BBSRT_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic [DATA_WIDTH-1:0] quotient,
   output div_stat_type          stat
);

   localparam int CMP_WIDTH = 2 * DATA_WIDTH + FRACTION_BITS;
   localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);

   localparam logic [1:0] DV_IDLE  = 2'd0;
   localparam logic [1:0] DV_CHECK = 2'd1;
   localparam logic [1:0] DV_RUN   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic                  done_ff, done_in;

   logic [CMP_WIDTH-1:0]  scaled_num;
   logic [CMP_WIDTH-1:0]  scaled_den;
   logic                  too_big;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   trial_diff;
   logic                  fits;

   // Quotient fits in DATA_WIDTH bits exactly when N < den << DATA_WIDTH.
   assign scaled_num = CMP_WIDTH'(num_ff) << FRACTION_BITS;
   assign scaled_den = CMP_WIDTH'(den_ff) << DATA_WIDTH;
   assign too_big    = scaled_num >= scaled_den;

   // Shared subtract-compare step: bring down one dividend bit.
   assign trial      = {rem_ff, shift_ff[DATA_WIDTH-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (ctrl.start) begin
               num_in   = dividend;
               den_in   = divisor;
               state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            ovf_in = too_big;
            if (too_big) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               rem_in   = scaled_num[DATA_WIDTH +: DATA_WIDTH];
               shift_in = scaled_num[DATA_WIDTH-1:0];
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in   = fits ? trial_diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            shift_in = {shift_ff[DATA_WIDTH-2:0], fits};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1)) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign quotient      = shift_ff;
   assign stat.done     = done_ff;
   assign stat.overflow = ovf_ff;

endmodule

// ===== hw/rtl/box_bound_step_ratio_test.sv =====
// Box bound step ratio test, top level: sequencer, running minimum, result register.
// Depends on bbsrt_pkg, bbsrt_req_if, bbsrt_rsp_if and bbsrt_divider.
//
// Usage:
//   req_chan carries one vector element per word: position, both bounds with
//   their finite flags, the direction component and the final-element mark.
//   rsp_chan returns one word per element: the breakpoint (or infinite flag),
//   the running minimum of the vector so far and vector_done.
//   All values are signed fixed point, DATA_WIDTH bits with FRACTION_BITS
//   fraction bits; quotients beyond range saturate.
// Sequence:
//   A finite breakpoint passes through setup, the overflow check, one divider
//   step per quotient bit, the divider's done flag and finish before it is
//   offered on rsp; the sequencer then returns to idle and takes the next
//   element. The restoring divider does one subtract-compare per bit. An
//   overflowing quotient ends after the check; an infinite breakpoint skips
//   the divider.
// Reset (synchronous): drop any element in work, clear the result register
//   and return the running minimum to zero, infinite.
// Stall: a finished word waits in the result register; the next element is
//   still accepted and works up to its finish, then holds until rsp is taken.
module box_bound_step_ratio_test import bbsrt_pkg::*; #(
   parameter int DATA_WIDTH    = BBSRT_DATA_WIDTH,
   parameter int FRACTION_BITS = BBSRT_FRACTION_BITS
) (
   input logic       clock,
   input logic       reset,
   bbsrt_req_if.sink   req_chan,
   bbsrt_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SETUP  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   // Element held for the whole computation
   logic [DATA_WIDTH-1:0] pos_ff, up_ff, lo_ff, dir_ff;
   logic                  up_fin_ff, lo_fin_ff, last_ff;

   // Setup results
   logic neg_ff, neg_in;
   logic inf_ff, inf_in;

   // Running minimum of the current vector
   logic [DATA_WIDTH-1:0] min_ff, min_in;
   logic                  min_inf_ff, min_inf_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_brk_ff, rsp_min_ff;
   logic                  rsp_brk_inf_ff, rsp_min_inf_ff, rsp_done_ff;

   logic                  req_take;
   logic                  load_rsp;

   // Setup datapath
   logic                  dir_neg, dir_zero, use_upper, use_lower;
   logic [DATA_WIDTH-1:0] bound;
   logic [DATA_WIDTH:0]   diff_c, diff_abs;
   logic                  num_neg;
   logic [DATA_WIDTH-1:0] num_c, den_c;
   logic                  neg_c;

   // Finish datapath
   logic [DATA_WIDTH-1:0] lim, q_sat, bp_val, new_min;
   logic                  take_min, new_min_inf;

   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   logic [DATA_WIDTH-1:0] div_quot;

   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign load_rsp       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Pick the bound the direction runs towards; zero direction has none.
   always_comb begin
      dir_neg   = dir_ff[DATA_WIDTH-1];
      dir_zero  = (dir_ff == '0);
      use_upper = dir_neg && up_fin_ff;
      use_lower = !dir_neg && !dir_zero && lo_fin_ff;
      bound     = use_upper ? up_ff : lo_ff;
      diff_c    = {pos_ff[DATA_WIDTH-1], pos_ff} - {bound[DATA_WIDTH-1], bound};
      num_neg   = diff_c[DATA_WIDTH];
      diff_abs  = num_neg ? (~diff_c + 1'b1) : diff_c;
      num_c     = diff_abs[DATA_WIDTH-1:0];
      den_c     = dir_neg ? (~dir_ff + 1'b1) : dir_ff;
      neg_c     = (num_neg != dir_neg) && (num_c != '0);
   end

   assign div_ctrl.start = (state_ff == ST_SETUP) && (use_upper || use_lower);

   bbsrt_divider #(
      .DATA_WIDTH    (DATA_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (num_c),
      .divisor  (den_c),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // Saturate, apply sign, fold into the running minimum.
   always_comb begin
      lim      = neg_ff ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      q_sat    = (div_stat.overflow || (div_quot > lim)) ? lim : div_quot;
      bp_val   = inf_ff ? '0 : (neg_ff ? (~q_sat + 1'b1) : q_sat);
      take_min = !inf_ff && (min_inf_ff || ($signed(bp_val) < $signed(min_ff)));
      new_min     = take_min ? bp_val : min_ff;
      new_min_inf = take_min ? 1'b0 : min_inf_ff;
   end

   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      inf_in     = inf_ff;
      min_in     = min_ff;
      min_inf_in = min_inf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            neg_in   = neg_c;
            inf_in   = !(use_upper || use_lower);
            state_in = (use_upper || use_lower) ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               // clear the minimum once the final element of a vector is out
               min_in     = last_ff ? '0 : new_min;
               min_inf_in = last_ff ? 1'b1 : new_min_inf;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '0;
         min_inf_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         min_inf_ff   <= min_inf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture the element on acceptance and the result on load, hold otherwise.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      inf_ff <= inf_in;
      if (req_take) begin
         pos_ff    <= req_chan.position;
         up_ff     <= req_chan.upper_bound;
         up_fin_ff <= req_chan.upper_finite;
         lo_ff     <= req_chan.lower_bound;
         lo_fin_ff <= req_chan.lower_finite;
         dir_ff    <= req_chan.step_direction;
         last_ff   <= req_chan.final_element;
      end
      if (load_rsp) begin
         rsp_brk_ff     <= bp_val;
         rsp_brk_inf_ff <= inf_ff;
         rsp_min_ff     <= new_min_inf ? '0 : new_min;
         rsp_min_inf_ff <= new_min_inf;
         rsp_done_ff    <= last_ff;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.breakpoint          = rsp_brk_ff;
   assign rsp_chan.breakpoint_infinite = rsp_brk_inf_ff;
   assign rsp_chan.min_step            = rsp_min_ff;
   assign rsp_chan.min_infinite        = rsp_min_inf_ff;
   assign rsp_chan.vector_done         = rsp_done_ff;

   // An accepted word always starts the setup step.
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SETUP))
      else $error("accepted word did not enter setup");

   // Divider only finishes while the sequencer waits for it.
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   // An infinite breakpoint is reported as zero.
   a_inf_brk_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_brk_inf_ff) |-> (rsp_brk_ff == '0))
      else $error("infinite breakpoint with non-zero value");

   // An infinite minimum is reported as zero.
   a_inf_min_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_min_inf_ff) |-> (rsp_min_ff == '0))
      else $error("infinite minimum with non-zero value");

   // The minimum returns to zero, infinite after the final element.
   a_min_cleared: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && last_ff) |=> (min_inf_ff && (min_ff == '0)))
      else $error("running minimum not cleared after final element");

endmodule
